// ----- rtl/core/jsu_pkg.sv -----
package jsu_pkg;

   typedef enum logic [1:0] {
      STATUS_DATA,
      STATUS_DONE,
      STATUS_NO_QUOTE,
      STATUS_UNTERMINATED
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      status_type status;
      logic       last;
   } result_type;

   localparam int unsigned GROUP_MAX = 4;
   localparam int unsigned GROUP_IDX_W = $clog2(GROUP_MAX);

   typedef struct packed {
      result_type [GROUP_MAX-1:0] item;
      logic [2:0]                 count;
   } group_type;

endpackage

// ----- rtl/core/json_string_unescape_utf8_top.sv -----
// A result is written into the result queue by the input transfer that causes it.
// Input is taken at one transfer per cycle while the queue has room; results leave
// one per cycle while the receiver is ready, and an input may yield up to four results.
// Input is taken while the eight-entry result queue holds four or fewer entries.
// Reset (synchronous, active high) empties the queue and returns to awaiting a quote.
module json_string_unescape_utf8_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] text_byte
   input  logic [0:0] req_tuser,  // [0] text_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_byte
   output logic [2:0] rsp_tuser,  // [0] byte_valid, [2:1] status
   output logic       rsp_tlast
);
   import jsu_pkg::*;

   logic       fire;
   group_type  group;
   result_type head;

   assign fire = req_tvalid && req_tready;

   jsu_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .text_byte (req_tdata),
      .text_end  (req_tuser[0]),
      .group     (group)
   );

   jsu_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .group_in   (group),
      .ready      (req_tready),
      .pop_ready  (rsp_tready),
      .head       (head),
      .head_valid (rsp_tvalid)
   );

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = {head.status, head.byte_valid};
   assign rsp_tlast = head.last;

endmodule

// ----- rtl/core/jsu_decoder.sv -----
module jsu_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         text_byte,
   input  logic               text_end,
   output jsu_pkg::group_type group
);
   import jsu_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_STR,
      PH_ESC,
      PH_HEX_FIRST,
      PH_AFTER_HIGH,
      PH_AFTER_HIGH_BS,
      PH_HEX_SECOND
   } phase_type;

   typedef struct packed {
      logic [3:0][7:0] b;
      logic [2:0]      n;
   } utf8_type;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_N         = 8'h6e;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;

   localparam logic [31:0] SUPP_BASE = 32'h0001_0000;
   localparam logic [31:0] LOW_BASE  = 32'h0000_dc00;
   localparam logic [5:0]  HIGH_TAG  = 6'b110110;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CHAR_N:  r = 8'h0a;
         CHAR_T:  r = 8'h09;
         CHAR_R:  r = 8'h0d;
         CHAR_B:  r = 8'h08;
         CHAR_F:  r = 8'h0c;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic utf8_type utf8(input logic [31:0] cp);
      utf8_type r;
      r = '0;
      if (cp < 32'h0000_0080) begin
         r.b[0] = cp[7:0];
         r.n    = 3'd1;
      end else if (cp < 32'h0000_0800) begin
         r.b[0] = 8'hc0 | {3'b000, cp[10:6]};
         r.b[1] = 8'h80 | {2'b00, cp[5:0]};
         r.n    = 3'd2;
      end else if (cp < 32'h0001_0000) begin
         r.b[0] = 8'he0 | {4'b0000, cp[15:12]};
         r.b[1] = 8'h80 | {2'b00, cp[11:6]};
         r.b[2] = 8'h80 | {2'b00, cp[5:0]};
         r.n    = 3'd3;
      end else begin
         r.b[0] = 8'hf0 | cp[25:18];
         r.b[1] = 8'h80 | {2'b00, cp[17:12]};
         r.b[2] = 8'h80 | {2'b00, cp[11:6]};
         r.b[3] = 8'h80 | {2'b00, cp[5:0]};
         r.n    = 3'd4;
      end
      return r;
   endfunction

   function automatic result_type data_item(input logic [7:0] b);
      result_type r;
      r            = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      r.status     = STATUS_DATA;
      return r;
   endfunction

   function automatic result_type status_item(input status_type s);
      result_type r;
      r        = '0;
      r.status = s;
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [15:0] hex_value_ff, hex_value_in;
   logic [2:0]  hex_count_ff, hex_count_in;
   logic        hex_stopped_ff, hex_stopped_in;
   logic [15:0] high_unit_ff, high_unit_in;

   logic [4:0]  digit;
   logic [15:0] hv_take;
   logic [2:0]  cnt_take;
   logic        stop_take;
   logic        full;
   logic [31:0] joined;
   logic [31:0] cp;
   logic        emit_utf8;
   logic        tail_valid;
   result_type  tail;
   utf8_type    enc;
   logic [2:0]  np;
   logic [2:0]  total;

   assign digit     = hex_digit(text_byte);
   assign hv_take   = (!hex_stopped_ff && digit[4]) ? {hex_value_ff[11:0], digit[3:0]}
                                                    : hex_value_ff;
   assign stop_take = hex_stopped_ff | ~digit[4];
   assign cnt_take  = hex_count_ff + 3'd1;
   assign full      = cnt_take[2];
   assign joined    = SUPP_BASE + {12'b0, high_unit_ff[9:0], 10'b0}
                      + ({16'b0, hv_take} - LOW_BASE);

   always_comb begin
      phase_in       = phase_ff;
      hex_value_in   = hex_value_ff;
      hex_count_in   = hex_count_ff;
      hex_stopped_in = hex_stopped_ff;
      high_unit_in   = high_unit_ff;
      cp             = '0;
      emit_utf8      = 1'b0;
      tail_valid     = 1'b0;
      tail           = '0;
      case (phase_ff)
         PH_STR: begin
            if (text_end) begin
               tail_valid = 1'b1;
               tail       = status_item(STATUS_UNTERMINATED);
               phase_in   = PH_IDLE;
            end else if (text_byte == CHAR_QUOTE) begin
               tail_valid = 1'b1;
               tail       = status_item(STATUS_DONE);
               phase_in   = PH_IDLE;
            end else if (text_byte == CHAR_BACKSLASH) begin
               phase_in = PH_ESC;
            end else begin
               tail_valid = 1'b1;
               tail       = data_item(text_byte);
            end
         end
         PH_ESC: begin
            if (text_end) begin
               tail_valid = 1'b1;
               tail       = status_item(STATUS_UNTERMINATED);
               phase_in   = PH_IDLE;
            end else if (text_byte == CHAR_U) begin
               hex_value_in   = '0;
               hex_count_in   = '0;
               hex_stopped_in = 1'b0;
               phase_in       = PH_HEX_FIRST;
            end else begin
               tail_valid = 1'b1;
               tail       = data_item(escape_map(text_byte));
               phase_in   = PH_STR;
            end
         end
         PH_HEX_FIRST: begin
            if (text_end) begin
               tail_valid = 1'b1;
               tail       = status_item(STATUS_UNTERMINATED);
               phase_in   = PH_IDLE;
            end else begin
               hex_value_in   = hv_take;
               hex_count_in   = cnt_take;
               hex_stopped_in = stop_take;
               if (full) begin
                  if (hv_take[15:10] == HIGH_TAG) begin
                     high_unit_in = hv_take;
                     phase_in     = PH_AFTER_HIGH;
                  end else begin
                     emit_utf8 = 1'b1;
                     cp        = {16'b0, hv_take};
                     phase_in  = PH_STR;
                  end
               end
            end
         end
         PH_AFTER_HIGH: begin
            cp = {16'b0, high_unit_ff};
            if (text_end) begin
               emit_utf8  = 1'b1;
               tail_valid = 1'b1;
               tail       = status_item(STATUS_UNTERMINATED);
               phase_in   = PH_IDLE;
            end else if (text_byte == CHAR_BACKSLASH) begin
               phase_in = PH_AFTER_HIGH_BS;
            end else if (text_byte == CHAR_QUOTE) begin
               emit_utf8  = 1'b1;
               tail_valid = 1'b1;
               tail       = status_item(STATUS_DONE);
               phase_in   = PH_IDLE;
            end else begin
               emit_utf8  = 1'b1;
               tail_valid = 1'b1;
               tail       = data_item(text_byte);
               phase_in   = PH_STR;
            end
         end
         PH_AFTER_HIGH_BS: begin
            cp = {16'b0, high_unit_ff};
            if (text_end) begin
               emit_utf8  = 1'b1;
               tail_valid = 1'b1;
               tail       = status_item(STATUS_UNTERMINATED);
               phase_in   = PH_IDLE;
            end else if (text_byte == CHAR_U) begin
               hex_value_in   = '0;
               hex_count_in   = '0;
               hex_stopped_in = 1'b0;
               phase_in       = PH_HEX_SECOND;
            end else begin
               emit_utf8  = 1'b1;
               tail_valid = 1'b1;
               tail       = data_item(escape_map(text_byte));
               phase_in   = PH_STR;
            end
         end
         PH_HEX_SECOND: begin
            if (text_end) begin
               tail_valid = 1'b1;
               tail       = status_item(STATUS_UNTERMINATED);
               phase_in   = PH_IDLE;
            end else begin
               hex_value_in   = hv_take;
               hex_count_in   = cnt_take;
               hex_stopped_in = stop_take;
               if (full) begin
                  emit_utf8 = 1'b1;
                  cp        = joined;
                  phase_in  = PH_STR;
               end
            end
         end
         default: begin
            if (text_end || text_byte != CHAR_QUOTE) begin
               tail_valid = 1'b1;
               tail       = status_item(STATUS_NO_QUOTE);
               phase_in   = PH_IDLE;
            end else begin
               phase_in = PH_STR;
            end
         end
      endcase
   end

   assign enc   = utf8(cp);
   assign np    = emit_utf8 ? enc.n : 3'd0;
   assign total = np + {2'b00, tail_valid};

   always_comb begin
      group       = '0;
      group.count = total;
      for (int k = 0; k < GROUP_MAX; k++) begin
         if (3'(k) < np) begin
            group.item[k] = data_item(enc.b[k]);
         end else if (tail_valid && 3'(k) == np) begin
            group.item[k] = tail;
         end
         group.item[k].last = (3'(k) == total - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         hex_value_ff   <= '0;
         hex_count_ff   <= '0;
         hex_stopped_ff <= 1'b0;
         high_unit_ff   <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         hex_value_ff   <= hex_value_in;
         hex_count_ff   <= hex_count_in;
         hex_stopped_ff <= hex_stopped_in;
         high_unit_ff   <= high_unit_in;
      end
   end

   a_hex_count_range : assert property (@(posedge clock) disable iff (reset)
      hex_count_ff <= 3'd4)
      else $error("hex window count past four characters");

   a_high_unit_held : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_AFTER_HIGH || phase_ff == PH_AFTER_HIGH_BS ||
       phase_ff == PH_HEX_SECOND) |-> high_unit_ff[15:10] == HIGH_TAG)
      else $error("pending high unit is not a high surrogate");

endmodule

// ----- rtl/core/jsu_out_queue.sv -----
module jsu_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu_pkg::group_type  group_in,
   output logic                ready,
   input  logic                pop_ready,
   output jsu_pkg::result_type head,
   output logic                head_valid
);
   import jsu_pkg::*;

   localparam int unsigned QDEPTH = 8;
   localparam int unsigned CW = $clog2(QDEPTH + 1);

   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            base;
   logic                     pop;
   result_type [QDEPTH-1:0]  slot_ff, slot_in;

   assign head_valid = count_ff != '0;
   assign head       = slot_ff[0];
   assign pop        = head_valid && pop_ready;
   assign base       = count_ff - CW'(pop);
   assign ready      = count_ff <= CW'(QDEPTH - GROUP_MAX);
   assign count_in   = base + (push ? CW'(group_in.count) : '0);

   for (genvar i = 0; i < QDEPTH; i++) begin : g_slot
      logic [CW-1:0] offset;
      result_type    shifted;
      if (i == QDEPTH - 1) begin : g_end
         assign shifted = slot_ff[i];
      end else begin : g_mid
         assign shifted = slot_ff[i+1];
      end
      assign offset     = CW'(i) - base;
      assign slot_in[i] = (CW'(i) < base) ? (pop ? shifted : slot_ff[i]) :
                          (push && offset < CW'(group_in.count)) ?
                             group_in.item[offset[GROUP_IDX_W-1:0]] : slot_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QDEPTH))
      else $error("result queue count past depth");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff <= CW'(QDEPTH - GROUP_MAX))
      else $error("result group pushed without room");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import jsu_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_COUNT = 4;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int MAX_PRINTED = 100;

   typedef enum logic [2:0] {
      DEC_IDLE,
      DEC_STR,
      DEC_ESC,
      DEC_HEX_FIRST,
      DEC_AFTER_HIGH,
      DEC_AFTER_HIGH_BS,
      DEC_HEX_SECOND
   } decode_phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_end;
   } text_xfer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;  // [7:0] text_byte
   logic [0:0] req_tuser = 1'b0;   // [0] text_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] out_byte
   logic [2:0] rsp_tuser;          // [0] byte_valid, [2:1] status
   logic       rsp_tlast;

   text_xfer_type text_q[$];
   result_type    decoded_q[$];
   text_xfer_type xfer;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int items_queued = 0;

   int send_idle_tbl[PHASE_COUNT] = '{0, 62, 0, 32};
   int recv_idle_tbl[PHASE_COUNT] = '{0, 0, 62, 32};

   decode_phase_type dec_phase = DEC_IDLE;
   logic [15:0]      hex_value = 16'h0000;
   logic [2:0]       hex_count = 3'd0;
   logic             hex_stopped = 1'b0;
   logic [15:0]      high_unit = 16'h0000;

   json_string_unescape_utf8_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   function void push_result(logic [7:0] b, logic valid, status_type st);
      result_type r;
      r.out_byte = b;
      r.byte_valid = valid;
      r.status = st;
      r.last = 1'b0;
      decoded_q.push_back(r);
   endfunction

   function void push_utf8(logic [31:0] cp);
      if (cp < 32'h80) begin
         push_result(cp[7:0], 1'b1, STATUS_DATA);
      end else if (cp < 32'h800) begin
         push_result(8'(32'hc0 | (cp >> 6)), 1'b1, STATUS_DATA);
         push_result(8'(32'h80 | (cp & 32'h3f)), 1'b1, STATUS_DATA);
      end else if (cp < 32'h10000) begin
         push_result(8'(32'he0 | (cp >> 12)), 1'b1, STATUS_DATA);
         push_result(8'(32'h80 | ((cp >> 6) & 32'h3f)), 1'b1, STATUS_DATA);
         push_result(8'(32'h80 | (cp & 32'h3f)), 1'b1, STATUS_DATA);
      end else begin
         push_result(8'(32'hf0 | (cp >> 18)), 1'b1, STATUS_DATA);
         push_result(8'(32'h80 | ((cp >> 12) & 32'h3f)), 1'b1, STATUS_DATA);
         push_result(8'(32'h80 | ((cp >> 6) & 32'h3f)), 1'b1, STATUS_DATA);
         push_result(8'(32'h80 | (cp & 32'h3f)), 1'b1, STATUS_DATA);
      end
   endfunction

   function logic [7:0] unescape_char(logic [7:0] c);
      case (c)
         "n":     return 8'h0a;
         "t":     return 8'h09;
         "r":     return 8'h0d;
         "b":     return 8'h08;
         "f":     return 8'h0c;
         default: return c;
      endcase
   endfunction

   function int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function void start_window(decode_phase_type nxt);
      hex_value = 16'h0000;
      hex_count = 3'd0;
      hex_stopped = 1'b0;
      dec_phase = nxt;
   endfunction

   // consume one window character; true once four have been taken
   function bit take_window_char(logic [7:0] c);
      int d;
      d = hex_nibble(c);
      if (!hex_stopped && d >= 0) hex_value = {hex_value[11:0], 4'(d)};
      else hex_stopped = 1'b1;
      hex_count = hex_count + 3'd1;
      return hex_count >= 3'd4;
   endfunction

   function void string_char(logic [7:0] c);
      if (c == "\"") begin
         push_result(8'h00, 1'b0, STATUS_DONE);
         dec_phase = DEC_IDLE;
      end else if (c == "\\") begin
         dec_phase = DEC_ESC;
      end else begin
         push_result(c, 1'b1, STATUS_DATA);
         dec_phase = DEC_STR;
      end
   endfunction

   function void decode_text(logic [7:0] c, logic text_end);
      int         first;
      result_type tail;
      logic [31:0] cp;
      first = decoded_q.size();
      case (dec_phase)
         DEC_STR: begin
            if (text_end) begin
               push_result(8'h00, 1'b0, STATUS_UNTERMINATED);
               dec_phase = DEC_IDLE;
            end else string_char(c);
         end
         DEC_ESC: begin
            if (text_end) begin
               push_result(8'h00, 1'b0, STATUS_UNTERMINATED);
               dec_phase = DEC_IDLE;
            end else if (c == "u") begin
               start_window(DEC_HEX_FIRST);
            end else begin
               push_result(unescape_char(c), 1'b1, STATUS_DATA);
               dec_phase = DEC_STR;
            end
         end
         DEC_HEX_FIRST: begin
            if (text_end) begin
               push_result(8'h00, 1'b0, STATUS_UNTERMINATED);
               dec_phase = DEC_IDLE;
            end else if (take_window_char(c)) begin
               if (hex_value >= 16'hd800 && hex_value < 16'hdc00) begin
                  high_unit = hex_value;
                  dec_phase = DEC_AFTER_HIGH;
               end else begin
                  push_utf8({16'h0000, hex_value});
                  dec_phase = DEC_STR;
               end
            end
         end
         DEC_AFTER_HIGH: begin
            if (text_end) begin
               push_utf8({16'h0000, high_unit});
               push_result(8'h00, 1'b0, STATUS_UNTERMINATED);
               dec_phase = DEC_IDLE;
            end else if (c == "\\") begin
               dec_phase = DEC_AFTER_HIGH_BS;
            end else begin
               push_utf8({16'h0000, high_unit});
               string_char(c);
            end
         end
         DEC_AFTER_HIGH_BS: begin
            if (text_end) begin
               push_utf8({16'h0000, high_unit});
               push_result(8'h00, 1'b0, STATUS_UNTERMINATED);
               dec_phase = DEC_IDLE;
            end else if (c == "u") begin
               start_window(DEC_HEX_SECOND);
            end else begin
               push_utf8({16'h0000, high_unit});
               push_result(unescape_char(c), 1'b1, STATUS_DATA);
               dec_phase = DEC_STR;
            end
         end
         DEC_HEX_SECOND: begin
            if (text_end) begin
               push_result(8'h00, 1'b0, STATUS_UNTERMINATED);
               dec_phase = DEC_IDLE;
            end else if (take_window_char(c)) begin
               cp = 32'h10000 + ((32'(high_unit) - 32'hd800) << 10)
                    + (32'(hex_value) - 32'hdc00);
               push_utf8(cp);
               dec_phase = DEC_STR;
            end
         end
         default: begin
            if (text_end || c != "\"") push_result(8'h00, 1'b0, STATUS_NO_QUOTE);
            else dec_phase = DEC_STR;
         end
      endcase
      if (decoded_q.size() > first) begin
         tail = decoded_q.pop_back();
         tail.last = 1'b1;
         decoded_q.push_back(tail);
      end
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < MAX_PRINTED) $display("mismatch @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_result();
      result_type want;
      if (decoded_q.size() == 0) begin
         report_mismatch($sformatf("unexpected transfer data=%02h user=%03b last=%0b",
                                   rsp_tdata, rsp_tuser, rsp_tlast));
      end else begin
         want = decoded_q.pop_front();
         if (rsp_tdata !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", rsp_tdata, want.out_byte));
         if (rsp_tuser[0] !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %0b, want %0b", rsp_tuser[0],
                                      want.byte_valid));
         if (rsp_tuser[2:1] !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp_tuser[2:1], want.status));
         if (rsp_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", rsp_tlast, want.last));
      end
   endtask

   // driver: advance the pending queue, predict on every input transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) decode_text(req_tdata, req_tuser[0]);
         if (!req_tvalid || req_tready) begin
            if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               xfer = text_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= xfer.text_byte;
               req_tuser <= xfer.text_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic push_text(logic [7:0] b);
      text_xfer_type t;
      t.text_byte = b;
      t.text_end = 1'b0;
      text_q.push_back(t);
      items_queued++;
   endtask

   task automatic push_end();
      text_xfer_type t;
      t.text_byte = 8'($urandom_range(255));
      t.text_end = 1'b1;
      text_q.push_back(t);
      items_queued++;
   endtask

   task automatic push_chars(string s);
      for (int i = 0; i < s.len(); i++) push_text(s[i]);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'(8'h30 + n);
      if ($urandom_range(1)) return 8'(8'h61 + n - 4'd10);
      return 8'(8'h41 + n - 4'd10);
   endfunction

   task automatic push_unit(logic [15:0] v);
      push_chars("\\u");
      for (int i = 3; i >= 0; i--) push_text(hex_char(v[4*i +: 4]));
   endtask

   task automatic add_random_string();
      string       simple_esc;
      int          elems;
      int          k;
      logic [15:0] v;
      simple_esc = "ntrbf\"\\/";
      if ($urandom_range(99) < 10) begin
         if ($urandom_range(1)) push_end();
         else push_text(8'($urandom_range(255)));
      end
      push_chars("\"");
      elems = $urandom_range(8);
      for (int e = 0; e < elems; e++) begin
         k = $urandom_range(99);
         if (k < 35) begin
            push_text(8'($urandom_range(255)));
         end else if (k < 55) begin
            push_chars("\\");
            if ($urandom_range(3) != 0) push_text(simple_esc[$urandom_range(7)]);
            else push_text(8'($urandom_range(255)));
         end else if (k < 75) begin
            case ($urandom_range(3))
               0:       v = 16'($urandom_range(16'h7f));
               1:       v = 16'($urandom_range(16'h7ff, 16'h80));
               2:       v = 16'($urandom_range(16'hffff, 16'h800));
               default: v = 16'($urandom_range(16'hdbff, 16'hd800));
            endcase
            push_unit(v);
         end else if (k < 88) begin
            push_unit(16'($urandom_range(16'hdbff, 16'hd800)));
            if ($urandom_range(3) != 0) push_unit(16'($urandom_range(16'hdfff, 16'hdc00)));
            else push_unit(16'($urandom_range(16'hffff)));
         end else if (k < 94) begin
            push_chars("\\u");
            for (int i = 0; i < 4; i++) begin
               if ($urandom_range(1)) push_text(hex_char(4'($urandom_range(15))));
               else push_text(8'($urandom_range(255)));
            end
         end else begin
            // cut the text inside an escape or a window
            push_chars("\\");
            if ($urandom_range(1)) begin
               push_chars("u");
               for (int i = 0; i < $urandom_range(3); i++)
                  push_text(hex_char(4'($urandom_range(15))));
            end
            push_end();
            return;
         end
      end
      k = $urandom_range(99);
      if (k < 85) push_chars("\"");
      else if (k < 95) push_end();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      push_text("A");
      push_end();
      push_chars("\"");
      push_text(8'h00);
      push_text(8'hff);
      push_chars("\\n\\f\\\"\\u00zz\\uD83D\\uDE00");
      push_end();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         send_idle_pct = send_idle_tbl[p];
         recv_idle_pct = recv_idle_tbl[p];
         items_queued = 0;
         while (items_queued < ITEMS_PER_PHASE) add_random_string();
         while (text_q.size() != 0 || req_tvalid || decoded_q.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
